### src/irc_ccs_pkg.sv
// Package for the IRC color code stripper: payload types, control codes, byte judge function.
`default_nettype none
package irc_ccs_pkg;

  // Control codes of the IRC formatting set, plus comma, NUL and digit bounds
  localparam logic [7:0] CH_COLOR   = 8'h03;
  localparam logic [7:0] CH_BEEP    = 8'h07;
  localparam logic [7:0] CH_RESET   = 8'h0F;
  localparam logic [7:0] CH_REVERSE = 8'h16;
  localparam logic [7:0] CH_BOLD    = 8'h02;
  localparam logic [7:0] CH_UNDER   = 8'h1F;
  localparam logic [7:0] CH_ITALIC  = 8'h1D;
  localparam logic [7:0] CH_HIDDEN  = 8'h08;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  // Number of color digits armed by a color introducer or a comma
  localparam logic [1:0] COLOR_DIGITS = 2'd2;

  // Result queue depth and occupancy width
  localparam int QDEPTH  = 4;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       end_of_message;
  } res_item_t;

  // Per-message parsing state
  typedef struct packed {
    logic [1:0] digits_left;
    logic       in_background;
    logic       hidden_on;
  } parse_state_t;

  typedef struct packed {
    logic         keep;
    parse_state_t st;
  } judge_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Judge byte c given its lookahead nx; returns keep flag and updated state
  function automatic judge_t judge_byte(input logic [7:0] c, input logic [7:0] nx,
                                        input parse_state_t st, input logic hide_en);
    judge_t r;
    r.st   = st;
    r.keep = 1'b0;
    if (st.digits_left != 2'd0 &&
        (is_digit(c) || (c == CH_COMMA && is_digit(nx) && !st.in_background))) begin
      if (nx != CH_COMMA) begin
        r.st.digits_left = st.digits_left - 2'd1;
      end
      if (c == CH_COMMA) begin
        r.st.digits_left   = COLOR_DIGITS;
        r.st.in_background = 1'b1;
      end
    end else begin
      r.st.digits_left   = 2'd0;
      r.st.in_background = 1'b0;
      case (c)
        CH_COLOR: begin
          r.st.digits_left = COLOR_DIGITS;
        end
        CH_BEEP, CH_RESET, CH_REVERSE, CH_BOLD, CH_UNDER, CH_ITALIC: begin
          r.keep = 1'b0;
        end
        CH_HIDDEN: begin
          r.st.hidden_on = ~st.hidden_on;
        end
        default: begin
          r.keep = ~(st.hidden_on & hide_en);
        end
      endcase
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### src/irc_color_code_stripper_unit.sv
// IRC color code stripper: one byte of lookahead, formatting removal, result queue.
//
//  channel | signals                        | payload
//  --------+--------------------------------+-------------------------------------
//  in      | in_valid, in_ready, in_item    | in_byte, last
//  res     | res_valid, res_ready, res_item | out_byte, out_valid, end_of_message
//  cfg     | cfg_valid, cfg_ready, cfg_data | hide_en
//
// One byte is judged per cycle while in_ready is high, against the held byte; a final byte
// also judges itself against NUL, so a last transaction can push two results.
// Results go into a 4-entry queue; input is taken while at least two slots are
// free, so ordinary bytes flow at one per cycle while the res side keeps up.
// Reset (rst, synchronous) empties the queue and clears all parsing state.
// A stalled res side fills the queue and then drops in_ready.
`default_nettype none
module irc_color_code_stripper_unit (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  output logic                     in_ready,
  input  irc_ccs_pkg::in_item_t    in_item,
  output logic                     res_valid,
  input  wire                      res_ready,
  output irc_ccs_pkg::res_item_t   res_item,
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire                      cfg_data
);
  import irc_ccs_pkg::*;

  logic              hide_en;
  logic [7:0]        held_byte;
  logic              held_valid;
  parse_state_t      pstate;
  res_item_t         q [QDEPTH];
  logic [QCNT_W-1:0] count;

  logic              in_acc;
  logic              pop;
  judge_t            j0;
  judge_t            j1;
  parse_state_t      st_mid;
  logic              push0;
  logic              push1;
  res_item_t         e0;
  res_item_t         e1;
  res_item_t         q_next [QDEPTH];
  logic [QCNT_W-1:0] base;
  logic [QCNT_W-1:0] count_next;

  // Handshakes
  assign cfg_ready = 1'b1;
  assign res_valid = (count != '0);
  assign res_item  = q[0];
  assign in_ready  = (count <= QCNT_W'(QDEPTH - 2));
  assign in_acc    = in_valid & in_ready;
  assign pop       = res_valid & res_ready;

  // Judge held byte against the new byte, then the final byte against NUL
  always_comb begin
    j0     = judge_byte(held_byte, in_item.in_byte, pstate, hide_en);
    st_mid = held_valid ? j0.st : pstate;
    j1     = judge_byte(in_item.in_byte, CH_NUL, st_mid, hide_en);
    push0  = in_acc & held_valid & j0.keep;
    push1  = in_acc & in_item.last;
    e0.out_byte       = held_byte;
    e0.out_valid      = 1'b1;
    e0.end_of_message = 1'b0;
    e1.out_byte       = j1.keep ? in_item.in_byte : 8'h00;
    e1.out_valid      = j1.keep;
    e1.end_of_message = 1'b1;
  end

  // Result queue: shift on pop, append up to two entries
  always_comb begin
    base = count - QCNT_W'(pop);
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && i + 1 < QDEPTH) begin
        q_next[i] = q[i + 1];
      end else begin
        q_next[i] = q[i];
      end
      if (push0 && base == QCNT_W'(i)) begin
        q_next[i] = e0;
      end
      if (push1 && !push0 && base == QCNT_W'(i)) begin
        q_next[i] = e1;
      end
      if (push1 && push0 && base + QCNT_W'(1) == QCNT_W'(i)) begin
        q_next[i] = e1;
      end
    end
    count_next = base + QCNT_W'(push0) + QCNT_W'(push1);
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

  // Control and parsing state
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      hide_en    <= 1'b0;
      held_valid <= 1'b0;
      held_byte  <= 8'h00;
      pstate     <= '0;
    end else begin
      count <= count_next;
      if (cfg_valid) begin
        hide_en <= cfg_data;
      end
      if (in_acc) begin
        if (in_item.last) begin
          held_valid <= 1'b0;
          held_byte  <= 8'h00;
          pstate     <= '0;
        end else begin
          held_valid <= 1'b1;
          held_byte  <= in_item.in_byte;
          pstate     <= st_mid;
        end
      end
    end
  end

endmodule
`default_nettype wire
